// ===== design/alr_pkg.sv =====
// Shared constants, types and the helper function of the antialiased line rasterizer.
package alr_pkg;

    localparam int COORD_BITS    = 13;
    localparam int FRAC_BITS     = 16;
    localparam int LEVELS        = 256;
    localparam int LEVEL_BITS    = $clog2(LEVELS);
    localparam int INT_BITS      = 8;
    localparam int VAL_BITS      = 8;
    localparam int CFG_BITS      = 13;
    localparam int CFG_RESET     = 4096;
    localparam int ADDR_BITS     = 3;
    localparam int CW            = COORD_BITS + 1;
    localparam int ACC_BITS      = FRAC_BITS + CW;
    localparam int DIVIDEND_BITS = COORD_BITS + FRAC_BITS;
    localparam int CNT_BITS      = $clog2(DIVIDEND_BITS);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [CW-1:0]         t_wcoord;
    typedef logic signed [ACC_BITS-1:0]   t_acc;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_STEP  = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PREP,
        ST_EP0,
        ST_EP1,
        ST_RD_LO,
        ST_RD_HI,
        ST_OUT0,
        ST_OUT1
    } t_state;

    typedef enum logic [1:0] {
        OUT_EP0,
        OUT_EP1,
        OUT_ST0,
        OUT_ST1
    } t_out_sel;

    typedef enum logic [1:0] {
        RD_INT,
        RD_LO,
        RD_HI
    } t_rd_sel;

    typedef struct packed {
        logic     tab_wr;
        logic     latch_start;
        logic     setup;
        logic     div_start;
        logic     prep;
        logic     mem_rd;
        t_rd_sel  rd_sel;
        logic     hold_lo;
        logic     out_load;
        t_out_sel out_sel;
        logic     step_adv;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic div_done;
        logic out_free;
    } t_status;

    // True when the pixel lies inside the image; the full coordinate is tested.
    function automatic logic in_image(t_wcoord px, t_wcoord py,
                                      logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
        logic signed [CW:0] xs;
        logic signed [CW:0] ys;
        logic signed [CW:0] ws;
        logic signed [CW:0] hs;
        xs = (CW+1)'(px);
        ys = (CW+1)'(py);
        ws = $signed((CW+1)'(w));
        hs = $signed((CW+1)'(h));
        return (xs >= 0) && (ys >= 0) && (xs < ws) && (ys < hs);
    endfunction

endpackage

// ===== design/alr_in_if.sv =====
// Input channel of the rasterizer: command words with valid/ready handshake.
interface alr_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     action;
    alr_pkg::t_coord                x_start;
    alr_pkg::t_coord                y_start;
    alr_pkg::t_coord                x_end;
    alr_pkg::t_coord                y_end;
    logic [alr_pkg::INT_BITS-1:0]   intensity;
    logic [alr_pkg::LEVEL_BITS-1:0] table_index;
    logic [alr_pkg::VAL_BITS-1:0]   table_value;

    modport source (
        output valid, action, x_start, y_start, x_end, y_end,
               intensity, table_index, table_value,
        input  ready
    );
    modport sink (
        input  valid, action, x_start, y_start, x_end, y_end,
               intensity, table_index, table_value,
        output ready
    );
endinterface

// ===== design/alr_out_if.sv =====
// Output channel of the rasterizer: pixel words with valid/ready handshake.
interface alr_out_if;
    logic                         valid;
    logic                         ready;
    alr_pkg::t_coord              pixel_x;
    alr_pkg::t_coord              pixel_y;
    logic [alr_pkg::VAL_BITS-1:0] pixel_value;
    logic                         write_enable;
    logic                         last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_value, write_enable, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_value, write_enable, last,
        output ready
    );
endinterface

// ===== design/alr_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module alr_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [alr_pkg::DIVIDEND_BITS-1:0]   i_dividend,
    input  logic [alr_pkg::COORD_BITS-1:0]      i_divisor,
    output logic                                o_done,
    output logic [alr_pkg::DIVIDEND_BITS-1:0]   o_quotient
);
    import alr_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_BITS-1:0]      r_cnt;
    logic [COORD_BITS-1:0]    r_rem;
    logic [COORD_BITS-1:0]    r_div;
    logic [DIVIDEND_BITS-1:0] r_quo;
    logic [COORD_BITS:0]      trial;
    logic [COORD_BITS:0]      diff;
    logic                     ge;

    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_BITS-1]};
        diff  = trial - {1'b0, r_div};
        ge    = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DIVIDEND_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out of the top of the quotient register as quotient bits enter.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            r_quo <= {r_quo[DIVIDEND_BITS-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ===== design/alr_ctrl.sv =====
// Sequencer of the rasterizer: accepts commands and steps the datapath.
module alr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_action,
    output logic             o_ready,
    input  alr_pkg::t_status i_status,
    output alr_pkg::t_cmd    o_cmd
);
    import alr_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_action action;

    assign action = t_action'(i_action);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (action)
                        ACT_START: n_state = ST_SETUP;
                        ACT_STEP:  n_state = i_status.active ? ST_RD_LO : ST_IDLE;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SETUP:    n_state = ST_DIV_GO;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: n_state = i_status.div_done ? ST_PREP : ST_DIV_WAIT;
            ST_PREP:     n_state = ST_EP0;
            ST_EP0:      n_state = i_status.out_free ? ST_EP1 : ST_EP0;
            ST_EP1:      n_state = i_status.out_free ? ST_IDLE : ST_EP1;
            ST_RD_LO:    n_state = ST_RD_HI;
            ST_RD_HI:    n_state = ST_OUT0;
            ST_OUT0:     n_state = i_status.out_free ? ST_OUT1 : ST_OUT0;
            ST_OUT1:     n_state = i_status.out_free ? ST_IDLE : ST_OUT1;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (action)
                        ACT_LOAD:  o_cmd.tab_wr      = 1'b1;
                        ACT_START: o_cmd.latch_start = 1'b1;
                        default:   o_cmd.tab_wr      = 1'b0;
                    endcase
                end
            end
            ST_SETUP:    o_cmd.setup     = 1'b1;
            ST_DIV_GO:   o_cmd.div_start = 1'b1;
            ST_DIV_WAIT: o_cmd.div_start = 1'b0;
            ST_PREP: begin
                o_cmd.prep   = 1'b1;
                o_cmd.mem_rd = 1'b1;
                o_cmd.rd_sel = RD_INT;
            end
            ST_EP0: begin
                o_cmd.out_sel  = OUT_EP0;
                o_cmd.out_load = i_status.out_free;
            end
            ST_EP1: begin
                o_cmd.out_sel  = OUT_EP1;
                o_cmd.out_load = i_status.out_free;
            end
            ST_RD_LO: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.rd_sel = RD_LO;
            end
            ST_RD_HI: begin
                o_cmd.mem_rd  = 1'b1;
                o_cmd.rd_sel  = RD_HI;
                o_cmd.hold_lo = 1'b1;
            end
            ST_OUT0: begin
                o_cmd.out_sel  = OUT_ST0;
                o_cmd.out_load = i_status.out_free;
            end
            ST_OUT1: begin
                o_cmd.out_sel  = OUT_ST1;
                o_cmd.out_load = i_status.out_free;
                o_cmd.step_adv = i_status.out_free;
            end
            default: o_ready = 1'b0;
        endcase
    end
endmodule

// ===== design/alr_dp.sv =====
// Datapath of the rasterizer: endpoint setup, slope, accumulator, gamma table, output word.
module alr_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  alr_pkg::t_cmd                   i_cmd,
    output alr_pkg::t_status                o_status,
    input  alr_pkg::t_coord                 i_x_start,
    input  alr_pkg::t_coord                 i_y_start,
    input  alr_pkg::t_coord                 i_x_end,
    input  alr_pkg::t_coord                 i_y_end,
    input  logic [alr_pkg::INT_BITS-1:0]    i_intensity,
    input  logic [alr_pkg::LEVEL_BITS-1:0]  i_table_index,
    input  logic [alr_pkg::VAL_BITS-1:0]    i_table_value,
    input  logic [alr_pkg::CFG_BITS-1:0]    i_width,
    input  logic [alr_pkg::CFG_BITS-1:0]    i_height,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output alr_pkg::t_coord                 o_pixel_x,
    output alr_pkg::t_coord                 o_pixel_y,
    output logic [alr_pkg::VAL_BITS-1:0]    o_pixel_value,
    output logic                            o_write_enable,
    output logic                            o_last
);
    import alr_pkg::*;

    // Raw endpoints of the start word.
    t_coord                r_ax, r_ay, r_bx, r_by;
    logic [INT_BITS-1:0]   r_int;
    // Endpoints ordered along the major axis.
    t_wcoord               r_m0, r_n0, r_m1, r_n1;
    logic [COORD_BITS-1:0] r_dx;
    t_wcoord               r_dy;
    logic                  r_steep;
    // Line walk state.
    t_acc                  r_slope;
    t_acc                  r_acc;
    t_wcoord               r_col;
    t_wcoord               r_end;
    logic                  r_active;
    // Gamma table and its read port.
    logic [VAL_BITS-1:0]   r_gamma [LEVELS];
    logic [VAL_BITS-1:0]   r_rdata;
    logic [VAL_BITS-1:0]   r_lo_val;
    // Output register.
    logic                  r_out_valid;
    t_coord                r_px, r_py;
    logic [VAL_BITS-1:0]   r_val;
    logic                  r_we;
    logic                  r_last;

    t_wcoord ax, ay, bx, by, dxs, dys, adx, ady;
    t_wcoord m0, n0, m1, n1;
    logic    steep;
    t_wcoord ady_abs;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [DIVIDEND_BITS-1:0] quotient;
    logic                     div_done;
    t_acc    slope_val;
    t_acc    slope_mag;
    t_wcoord row, row1, col1;
    logic [FRAC_BITS-1:0]        frac;
    logic [FRAC_BITS:0]          wlo;
    logic [INT_BITS+FRAC_BITS:0] prod_lo;
    logic [INT_BITS+FRAC_BITS:0] prod_hi;
    logic [LEVEL_BITS-1:0]       lvl_lo, lvl_hi, rd_addr;
    logic    out_free;
    t_wcoord sel_x, sel_y;
    logic [VAL_BITS-1:0] sel_val;
    logic    sel_last;

    // Steepness test and endpoint ordering.
    always_comb begin
        ax  = CW'(r_ax);
        ay  = CW'(r_ay);
        bx  = CW'(r_bx);
        by  = CW'(r_by);
        dxs = bx - ax;
        dys = by - ay;
        adx = dxs[CW-1] ? -dxs : dxs;
        ady = dys[CW-1] ? -dys : dys;
        steep = ady > adx;
        if (steep) begin
            m0 = ay; n0 = ax; m1 = by; n1 = bx;
        end else begin
            m0 = ax; n0 = ay; m1 = bx; n1 = by;
        end
        if (m0 > m1) begin
            {m0, m1} = {m1, m0};
            {n0, n1} = {n1, n0};
        end
    end

    always_comb begin
        ady_abs   = r_dy[CW-1] ? -r_dy : r_dy;
        dividend  = {ady_abs[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
        slope_mag = ACC_BITS'(quotient);
        if (r_dx == '0) begin
            slope_val = ACC_BITS'(1) <<< FRAC_BITS;
        end else begin
            slope_val = r_dy[CW-1] ? -slope_mag : slope_mag;
        end
    end

    alr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_dx),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Row, coverage weights and the levels they select.
    always_comb begin
        row     = r_acc[ACC_BITS-1 -: CW];
        row1    = row + CW'(1);
        col1    = r_col + CW'(1);
        frac    = r_acc[FRAC_BITS-1:0];
        wlo     = (FRAC_BITS+1)'(1) << FRAC_BITS;
        wlo     = wlo - (FRAC_BITS+1)'(frac);
        prod_lo = (INT_BITS+FRAC_BITS+1)'(r_int) * (INT_BITS+FRAC_BITS+1)'(wlo);
        prod_hi = (INT_BITS+FRAC_BITS+1)'(r_int) * (INT_BITS+FRAC_BITS+1)'(frac);
        lvl_lo  = prod_lo[FRAC_BITS +: LEVEL_BITS];
        lvl_hi  = prod_hi[FRAC_BITS +: LEVEL_BITS];
        case (i_cmd.rd_sel)
            RD_LO:   rd_addr = lvl_lo;
            RD_HI:   rd_addr = lvl_hi;
            default: rd_addr = LEVEL_BITS'(r_int);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tab_wr) begin
            r_gamma[i_table_index] <= i_table_value;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_gamma[rd_addr];
        end
        if (i_cmd.hold_lo) begin
            r_lo_val <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_start) begin
            r_ax  <= i_x_start;
            r_ay  <= i_y_start;
            r_bx  <= i_x_end;
            r_by  <= i_y_end;
            r_int <= i_intensity;
        end
        if (i_cmd.setup) begin
            r_m0    <= m0;
            r_n0    <= n0;
            r_m1    <= m1;
            r_n1    <= n1;
            r_dx    <= COORD_BITS'(m1 - m0);
            r_dy    <= n1 - n0;
            r_steep <= steep;
        end
        if (i_cmd.prep) begin
            r_slope <= slope_val;
            r_acc   <= {r_n0, {FRAC_BITS{1'b0}}} + slope_val;
            r_col   <= r_m0 + CW'(1);
            r_end   <= r_m1;
        end else if (i_cmd.step_adv) begin
            r_acc <= r_acc + r_slope;
            r_col <= col1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.prep) begin
            r_active <= (r_m0 + CW'(1)) < r_m1;
        end else if (i_cmd.step_adv) begin
            r_active <= col1 < r_end;
        end
    end

    // Pixel word selection.
    always_comb begin
        case (i_cmd.out_sel)
            OUT_EP0: begin
                sel_x    = r_steep ? r_n0 : r_m0;
                sel_y    = r_steep ? r_m0 : r_n0;
                sel_val  = r_rdata;
                sel_last = 1'b0;
            end
            OUT_EP1: begin
                sel_x    = r_steep ? r_n1 : r_m1;
                sel_y    = r_steep ? r_m1 : r_n1;
                sel_val  = r_rdata;
                sel_last = !r_active;
            end
            OUT_ST0: begin
                sel_x    = r_steep ? row : r_col;
                sel_y    = r_steep ? r_col : row;
                sel_val  = r_lo_val;
                sel_last = 1'b0;
            end
            default: begin
                sel_x    = r_steep ? row1 : r_col;
                sel_y    = r_steep ? r_col : row1;
                sel_val  = r_rdata;
                sel_last = !(col1 < r_end);
            end
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_px   <= sel_x[COORD_BITS-1:0];
            r_py   <= sel_y[COORD_BITS-1:0];
            r_val  <= sel_val;
            r_we   <= in_image(sel_x, sel_y, i_width, i_height);
            r_last <= sel_last;
        end
    end

    assign o_status.active   = r_active;
    assign o_status.div_done = div_done;
    assign o_status.out_free = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_pixel_x      = r_px;
    assign o_pixel_y      = r_py;
    assign o_pixel_value  = r_val;
    assign o_write_enable = r_we;
    assign o_last         = r_last;
endmodule

// ===== design/antialiased_line_rasterizer_core.sv =====
// Top level of the antialiased line rasterizer: register port, sequencer and datapath.
//
// Wu-style antialiased line drawer. A load word (action 0) writes one entry of the
// 256-entry gamma table and produces nothing. A start word (action 1) orders the
// endpoints, runs a restoring divider for the slope, then sends the two endpoint
// pixels at full coverage; an output stall can hold it up. A step word (action 2)
// looks up the two coverage levels one after the other in the single-port gamma
// table and sends the two pixels through one output register; an output stall can
// hold it up too. One word is worked on at a time; the input is ready only between
// words. Steps while no line is active and action 3 are taken and dropped.
// image_width and image_height sit at byte addresses 0 and 4; the user must write
// them only while the block is idle, as the block itself does not enforce this.
module antialiased_line_rasterizer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    alr_in_if.sink                          i_line,
    alr_out_if.source                       o_pixel,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [alr_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import alr_pkg::*;

    logic [CFG_BITS-1:0] r_width;
    logic [CFG_BITS-1:0] r_height;
    logic                cfg_wr;
    t_cmd                cmd;
    t_status             status;
    logic                ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_BITS'(CFG_RESET);
            r_height <= CFG_BITS'(CFG_RESET);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[CFG_BITS-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_BITS-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            default:    prdata = '0;
        endcase
    end

    alr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_line.valid),
        .i_action (i_line.action),
        .o_ready  (ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    assign i_line.ready = ready;

    alr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_x_start      (i_line.x_start),
        .i_y_start      (i_line.y_start),
        .i_x_end        (i_line.x_end),
        .i_y_end        (i_line.y_end),
        .i_intensity    (i_line.intensity),
        .i_table_index  (i_line.table_index),
        .i_table_value  (i_line.table_value),
        .i_width        (r_width),
        .i_height       (r_height),
        .i_out_ready    (o_pixel.ready),
        .o_out_valid    (o_pixel.valid),
        .o_pixel_x      (o_pixel.pixel_x),
        .o_pixel_y      (o_pixel.pixel_y),
        .o_pixel_value  (o_pixel.pixel_value),
        .o_write_enable (o_pixel.write_enable),
        .o_last         (o_pixel.last)
    );
endmodule

// ===== tb/antialiased_line_rasterizer_core_test.sv =====
// Self-checking testbench of the antialiased line rasterizer core with its own line predictor.
`timescale 1ns / 100ps

module antialiased_line_rasterizer_core_test;
    import alr_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int         ONE_FX   = 1 << FRAC_BITS;

    typedef struct {
        logic [1:0]          action;
        t_coord              xs;
        t_coord              ys;
        t_coord              xe;
        t_coord              ye;
        logic [INT_BITS-1:0] level;
        logic [LEVEL_BITS-1:0] idx;
        logic [VAL_BITS-1:0] val;
    } t_line_word;

    typedef struct {
        t_coord              x;
        t_coord              y;
        logic [VAL_BITS-1:0] value;
        logic                we;
        logic                last;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    alr_in_if  line_if ();
    alr_out_if pixel_if ();

    antialiased_line_rasterizer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (line_if),
        .o_pixel (pixel_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: a private copy of the gamma table, line state and image size.
    logic [VAL_BITS-1:0] gamma_copy [LEVELS];
    t_wcoord             col_now;
    t_wcoord             col_end;
    t_acc                row_acc;
    t_acc                line_slope;
    logic                steep_now;
    logic                drawing;
    logic [INT_BITS-1:0] line_level;
    logic [CFG_BITS-1:0] img_w;
    logic [CFG_BITS-1:0] img_h;

    t_pixel pixel_q [$];
    int     errors     = 0;
    int     words_used = 0;
    int     gap_odds   = 4;
    bit     calm       = 1'b0;

    task automatic report_mismatch(string what);
        errors++;
        // Printing stops after a while so that a broken block cannot flood the log.
        if (errors <= 50)
            $display("ERROR at %0t: %s", $realtime, what);
    endtask

    function automatic void push_pixel(int px, int py, int level, logic is_last);
        t_pixel p;
        p.x     = t_coord'(px);
        p.y     = t_coord'(py);
        p.value = gamma_copy[LEVEL_BITS'(level % LEVELS)];
        p.we    = (px >= 0) && (py >= 0) && (px < int'(img_w)) && (py < int'(img_h));
        p.last  = is_last;
        pixel_q.push_back(p);
    endfunction

    function automatic void predict_word(t_line_word w);
        int     ax, ay, bx, by;
        int     m0, n0, m1, n1, t;
        int     dx, dy, frac, lo, hi, col, row_i;
        longint q;
        t_acc   row;
        logic   steep;
        logic   done;
        case (w.action)
            ACT_LOAD: begin
                gamma_copy[w.idx] = w.val;
                words_used++;
            end
            ACT_START: begin
                ax = int'(w.xs);
                ay = int'(w.ys);
                bx = int'(w.xe);
                by = int'(w.ye);
                steep = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
                if (steep) begin
                    m0 = ay; n0 = ax; m1 = by; n1 = bx;
                end else begin
                    m0 = ax; n0 = ay; m1 = bx; n1 = by;
                end
                if (m0 > m1) begin
                    t = m0; m0 = m1; m1 = t;
                    t = n0; n0 = n1; n1 = t;
                end
                dx = m1 - m0;
                dy = n1 - n0;
                if (dx == 0)
                    q = ONE_FX;
                else
                    q = (longint'(dy) * ONE_FX) / longint'(dx);
                line_slope = t_acc'(q);
                steep_now  = steep;
                line_level = w.level;
                col_now    = t_wcoord'(m0 + 1);
                col_end    = t_wcoord'(m1);
                row_acc    = t_acc'(longint'(n0) * ONE_FX + q);
                done       = !(col_now < col_end);
                drawing    = !done;
                if (steep) begin
                    push_pixel(n0, m0, int'(line_level), 1'b0);
                    push_pixel(n1, m1, int'(line_level), done);
                end else begin
                    push_pixel(m0, n0, int'(line_level), 1'b0);
                    push_pixel(m1, n1, int'(line_level), done);
                end
                words_used++;
            end
            ACT_STEP: begin
                if (drawing) begin
                    row   = row_acc >>> FRAC_BITS;
                    row_i = int'(row);
                    frac  = int'(row_acc[FRAC_BITS-1:0]);
                    lo    = (int'(line_level) * (ONE_FX - frac)) >> FRAC_BITS;
                    hi    = (int'(line_level) * frac) >> FRAC_BITS;
                    col   = int'(col_now);
                    col_now = col_now + CW'(1);
                    row_acc = row_acc + line_slope;
                    done    = !(col_now < col_end);
                    drawing = !done;
                    if (steep_now) begin
                        push_pixel(row_i, col, lo, 1'b0);
                        push_pixel(row_i + 1, col, hi, done);
                    end else begin
                        push_pixel(col, row_i, lo, 1'b0);
                        push_pixel(col, row_i + 1, hi, done);
                    end
                    words_used++;
                end
            end
            default: ;
        endcase
    endfunction

    // Every word starts fully random; unused fields keep their random content.
    function automatic t_line_word rand_word(logic [1:0] action);
        t_line_word w;
        w.action = action;
        w.xs     = t_coord'($urandom);
        w.ys     = t_coord'($urandom);
        w.xe     = t_coord'($urandom);
        w.ye     = t_coord'($urandom);
        w.level  = INT_BITS'($urandom);
        w.idx    = LEVEL_BITS'($urandom);
        w.val    = VAL_BITS'($urandom);
        return w;
    endfunction

    task automatic send_word(t_line_word w);
        int gap;
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            gap = $urandom_range(1, 12);
            line_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        line_if.valid       <= 1'b1;
        line_if.action      <= w.action;
        line_if.x_start     <= w.xs;
        line_if.y_start     <= w.ys;
        line_if.x_end       <= w.xe;
        line_if.y_end       <= w.ye;
        line_if.intensity   <= w.level;
        line_if.table_index <= w.idx;
        line_if.table_value <= w.val;
        @(posedge i_clk);
        while (line_if.ready !== 1'b1) @(posedge i_clk);
        predict_word(w);
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 1))
            send_word(rand_word(ACT_LOAD));
        else
            send_word(rand_word(ACT_NONE));
    endtask

    task automatic run_line(int ax, int ay, int bx, int by, int level, int steps);
        t_line_word w;
        w       = rand_word(ACT_START);
        w.xs    = t_coord'(ax);
        w.ys    = t_coord'(ay);
        w.xe    = t_coord'(bx);
        w.ye    = t_coord'(by);
        w.level = INT_BITS'(level);
        send_word(w);
        repeat (steps) begin
            if ($urandom_range(0, 19) == 0)
                send_noise();
            send_word(rand_word(ACT_STEP));
        end
    endtask

    function automatic int clamp_coord(int v);
        if (v < -4096)
            return -4096;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    task automatic draw_random_line();
        int span, ax, ay, bx, by, major, steps, pick, level;
        pick = $urandom_range(0, 9);
        span = (pick < 6) ? $urandom_range(0, 6) :
               (pick < 9) ? $urandom_range(7, 40) : $urandom_range(41, 150);
        if ($urandom_range(0, 1)) begin
            ax = $urandom_range(0, 300);
            ay = $urandom_range(0, 300);
        end else begin
            ax = int'($urandom_range(0, 8191)) - 4096;
            ay = int'($urandom_range(0, 8191)) - 4096;
        end
        bx = clamp_coord(ax + int'($urandom_range(0, 2 * span)) - span);
        by = clamp_coord(ay + int'($urandom_range(0, 2 * span)) - span);
        major = (bx > ax) ? bx - ax : ax - bx;
        if (((by > ay) ? by - ay : ay - by) > major)
            major = (by > ay) ? by - ay : ay - by;
        steps = (major > 1) ? major - 1 : 0;
        pick = $urandom_range(0, 9);
        // Some lines are cut short by the next start, others get spare steps while idle.
        if (pick == 0 && steps > 0)
            steps = $urandom_range(0, steps - 1);
        else if (pick == 1)
            steps += $urandom_range(1, 3);
        pick  = $urandom_range(0, 9);
        level = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255);
        gap_odds = $urandom_range(0, 1) ? 0 : 4;
        run_line(ax, ay, bx, by, level, steps);
    endtask

    task automatic random_lines(int count);
        int goal;
        goal = words_used + count;
        while (words_used < goal)
            draw_random_line();
    endtask

    // Lower valid, let every pixel drain, then give a start word time to settle.
    task automatic wait_drained();
        line_if.valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (48) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_BITS-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WIDTH)
            img_w = value;
        else
            img_h = value;
    endtask

    task automatic set_image(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
        wait_drained();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    task automatic test_idle_words();
        send_word(rand_word(ACT_STEP));
        send_word(rand_word(ACT_NONE));
    endtask

    task automatic test_gamma_fill();
        t_line_word w;
        for (int i = 0; i < LEVELS; i++) begin
            w     = rand_word(ACT_LOAD);
            w.idx = LEVEL_BITS'(i);
            send_word(w);
        end
    endtask

    task automatic test_corner_lines();
        run_line(10, 20, 10, 20, 200, 0);
        send_word(rand_word(ACT_STEP));
        run_line(7, 7, 8, 8, 255, 0);
        run_line(0, 0, 5, 2, 255, 4);
        run_line(3, 10, 0, 4, 100, 5);
        run_line(0, 5, 4, 2, 255, 3);
        // The lower row of this flat line sits one past the bottom and wraps.
        run_line(4090, 4095, 4094, 4095, 255, 3);
        run_line(-4096, -4096, 4095, 4095, 0, 1);
        run_line(4095, -4096, -4096, 4095, 255, 1);
        run_line(-4096, 4095, 4095, 4095, 128, 1);
    endtask

    task automatic test_image_bounds();
        logic [CFG_BITS-1:0] widths  [6];
        logic [CFG_BITS-1:0] heights [6];
        widths  = '{13'd0, 13'd1, 13'd8191, 13'd4096, 13'd0, 13'd1};
        heights = '{13'd0, 13'd8191, 13'd1, 13'd4096, 13'd0, 13'd4096};
        widths[4]  = CFG_BITS'($urandom_range(1, 4096));
        heights[4] = CFG_BITS'($urandom_range(1, 4096));
        for (int i = 0; i < 6; i++) begin
            set_image(widths[i], heights[i]);
            random_lines(70);
        end
    endtask

    task automatic test_random_lines();
        set_image(13'd640, 13'd480);
        random_lines(550);
        set_image(13'd4096, 13'd4096);
        random_lines(150);
    endtask

    task automatic test_steady_stream();
        calm = 1'b1;
        random_lines(180);
    endtask

    // Pixel side: takes each word with random back-pressure and checks it in order.
    initial begin : pixel_sink
        t_pixel exp;
        int     stall_left;
        int     quiet_left;
        stall_left = 0;
        quiet_left = 0;
        pixel_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && pixel_if.valid === 1'b1 && pixel_if.ready === 1'b1) begin
                if (pixel_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel x=%0d y=%0d v=%0d",
                        pixel_if.pixel_x, pixel_if.pixel_y, pixel_if.pixel_value));
                end else begin
                    exp = pixel_q.pop_front();
                    if (pixel_if.pixel_x !== exp.x || pixel_if.pixel_y !== exp.y ||
                        pixel_if.pixel_value !== exp.value ||
                        pixel_if.write_enable !== exp.we || pixel_if.last !== exp.last)
                        report_mismatch($sformatf(
                            "pixel x=%0d y=%0d v=%0d we=%b last=%b, want %0d %0d %0d %b %b",
                            pixel_if.pixel_x, pixel_if.pixel_y, pixel_if.pixel_value,
                            pixel_if.write_enable, pixel_if.last,
                            exp.x, exp.y, exp.value, exp.we, exp.last));
                end
            end
            if (calm || quiet_left > 0) begin
                if (quiet_left > 0)
                    quiet_left--;
                pixel_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                pixel_if.ready <= 1'b0;
            end else begin
                case ($urandom_range(0, 63))
                    0: begin
                        quiet_left = $urandom_range(50, 300);
                        pixel_if.ready <= 1'b1;
                    end
                    1, 2, 3, 4, 5, 6, 7: begin
                        stall_left = $urandom_range(1, 12) - 1;
                        pixel_if.ready <= 1'b0;
                    end
                    default: pixel_if.ready <= 1'b1;
                endcase
            end
        end
    end

    initial begin : run_tests
        img_w      = 13'd4096;
        img_h      = 13'd4096;
        col_now    = '0;
        col_end    = '0;
        row_acc    = '0;
        line_slope = '0;
        steep_now  = 1'b0;
        drawing    = 1'b0;
        line_level = '0;
        for (int i = 0; i < LEVELS; i++)
            gamma_copy[i] = '0;
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        line_if.valid       <= 1'b0;
        line_if.action      <= ACT_LOAD;
        line_if.x_start     <= '0;
        line_if.y_start     <= '0;
        line_if.x_end       <= '0;
        line_if.y_end       <= '0;
        line_if.intensity   <= '0;
        line_if.table_index <= '0;
        line_if.table_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_words();
        test_gamma_fill();
        test_corner_lines();
        test_image_bounds();
        test_random_lines();
        test_steady_stream();

        wait_drained();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
